>>> sv/bvm_pkg.sv
package bvm_pkg;

  localparam int DATA_DEPTH = 1024;
  localparam int CODE_DEPTH = 1024;
  localparam int DATA_AW    = $clog2(DATA_DEPTH);
  localparam int CODE_AW    = $clog2(CODE_DEPTH);

  // pc must be able to hold CODE_DEPTH itself; the port shows the low 11 bits
  localparam int PC_NEED  = $clog2(CODE_DEPTH + 1);
  localparam int OUT_PC_W = 11;
  localparam int PC_W     = (PC_NEED > OUT_PC_W) ? PC_NEED : OUT_PC_W;

  localparam int CLR_DEPTH = (DATA_DEPTH > CODE_DEPTH) ? DATA_DEPTH : CODE_DEPTH;
  localparam int CLR_AW    = $clog2(CLR_DEPTH);

  localparam int CMD_W    = 2;
  localparam int ADDR_W   = 10;
  localparam int BYTE_W   = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;

  localparam logic [CMD_W-1:0] CMD_WR_DATA = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_CODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_STEP    = 2'd2;
  localparam logic [CMD_W-1:0] CMD_RD_DATA = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXIT     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_PC   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_DEST = 3'd3;
  localparam logic [STATUS_W-1:0] ST_BAD_SRC  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BAD_OP   = 3'd5;
  localparam logic [STATUS_W-1:0] ST_DIV_ZERO = 3'd6;
  localparam logic [STATUS_W-1:0] ST_HALTED   = 3'd7;

  localparam logic [7:0] OP_ADD  = 8'h00;
  localparam logic [7:0] OP_SUB  = 8'h01;
  localparam logic [7:0] OP_MUL  = 8'h02;
  localparam logic [7:0] OP_DIV  = 8'h03;
  localparam logic [7:0] OP_EXIT = 8'h0f;

  localparam int IMM_BIT = 11;

  typedef logic [1:0] vsel_t;
  localparam vsel_t VSEL_ZERO = 2'd0;
  localparam vsel_t VSEL_RD   = 2'd1;
  localparam vsel_t VSEL_SRC  = 2'd2;

  typedef struct packed {
    logic                clr;
    logic                ld_in;
    logic                dwr;
    logic                cwr;
    logic                drd_in;
    logic                crd_pc;
    logic                ld_word;
    logic                drd_src;
    logic                drd_dst;
    logic                ld_src;
    logic                ld_dst;
    logic                div_start;
    logic                wb;
    logic                set_halt;
    logic                res;
    logic [STATUS_W-1:0] res_status;
    vsel_t               vsel;
  } bvm_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       halted;
    logic       pc_bad;
    logic       dst_bad;
    logic       src_bad;
    logic       src_imm;
    logic       sval_zero;
    logic       div_done;
    logic [7:0] opc;
  } bvm_stat_t;

endpackage

>>> sv/byte_memory_vm_executor.sv
// Byte machine with a data store of bytes and a code store of 32-bit words.
// Input: a command word is taken at a rising edge with start high and busy
// low. Commands: write data byte, write code word, run one step, read data
// byte. Busy stays high until the result has been issued.
// Output: one result per command, shown for one cycle with out_valid high.
// The receiver has no way to stall; the result is taken in that cycle.
// A step that is halted or hits a bad pc ends before the code fetch, a bad
// address ends after it, and add/sub/mul/exit/bad opcode end after the
// source and destination reads; a divide by a non-zero source also waits
// for the divider. Each store has a single read port: code fetch, source
// read and destination read go through them one after another, and the
// divider yields one quotient bit per cycle.
// A new command may be given in the cycle that out_valid is high.
// Reset: synchronous, active low. Afterwards both stores are swept to zero,
// one entry per cycle, over max(DATA_DEPTH, CODE_DEPTH) = 1024 entries, with
// busy high; pc and the halted flag are cleared at once.
module byte_memory_vm_executor (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [bvm_pkg::CMD_W-1:0]      in_command,
  input  logic [bvm_pkg::ADDR_W-1:0]     in_address,
  input  logic [bvm_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [bvm_pkg::WORD_W-1:0]     in_code_word,
  output logic                           out_valid,
  output logic [bvm_pkg::STATUS_W-1:0]   out_status,
  output logic [bvm_pkg::BYTE_W-1:0]     out_value,
  output logic [bvm_pkg::OUT_PC_W-1:0]   out_program_counter
);
  import bvm_pkg::*;

  bvm_cmd_t  cmd;
  bvm_stat_t stat;

  bvm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .stat       (stat),
    .cmd        (cmd),
    .busy       (busy)
  );

  bvm_dp u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_address          (in_address),
    .in_data_byte        (in_data_byte),
    .in_code_word        (in_code_word),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_value           (out_value),
    .out_program_counter (out_program_counter)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after a command was taken");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result issued without a command in progress");

  a_no_wb_when_halted: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |-> !stat.halted)
    else $error("write-back while halted");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.crd_pc |-> !stat.pc_bad)
    else $error("fetch with pc beyond code store");

endmodule

>>> sv/bvm_ram.sv
module bvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/bvm_div.sv
module bvm_div (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [7:0] divisor,
  output logic [7:0] quotient,
  output logic       done
);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] quo_r, quo_nxt;
  logic [7:0] dvs_r, dvs_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       busy_r, busy_nxt;
  logic [8:0] shifted;
  logic       fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    shifted = {rem_r, quo_r[7]};
    fits    = shifted >= {1'b0, dvs_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = 4'd8;
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r != 4'd0) begin
      rem_nxt = fits ? 8'(shifted - {1'b0, dvs_r}) : shifted[7:0];
      quo_nxt = {quo_r[6:0], fits};
      cnt_nxt = cnt_r - 4'd1;
    end else if (busy_r) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign quotient = quo_r;
  assign done     = busy_r && cnt_r == 4'd0;

endmodule

>>> sv/bvm_dp.sv
module bvm_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bvm_pkg::bvm_cmd_t              cmd,
  output bvm_pkg::bvm_stat_t             stat,
  input  logic [bvm_pkg::ADDR_W-1:0]     in_address,
  input  logic [bvm_pkg::BYTE_W-1:0]     in_data_byte,
  input  logic [bvm_pkg::WORD_W-1:0]     in_code_word,
  output logic                           out_valid,
  output logic [bvm_pkg::STATUS_W-1:0]   out_status,
  output logic [bvm_pkg::BYTE_W-1:0]     out_value,
  output logic [bvm_pkg::OUT_PC_W-1:0]   out_program_counter
);
  import bvm_pkg::*;

  logic [ADDR_W-1:0]   addr_r;
  logic [BYTE_W-1:0]   dbyte_r;
  logic [WORD_W-1:0]   cword_r;
  logic [WORD_W-1:0]   word_r;
  logic [7:0]          sval_r, dval_r;
  logic [PC_W-1:0]     pc_r, pc_nxt;
  logic                halted_r, halted_nxt;
  logic [CLR_AW-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [BYTE_W-1:0]   out_value_r;
  logic [OUT_PC_W-1:0] out_pc_r;

  logic [31:0] addr32, src32, dst32, pc32, clr32;
  logic        addr_data_ok, addr_code_ok;
  logic [11:0] src, dst;

  logic               d_we;
  logic [DATA_AW-1:0] d_waddr, d_raddr;
  logic [7:0]         d_wdata, d_rdata;
  logic               c_we;
  logic [CODE_AW-1:0] c_waddr;
  logic [WORD_W-1:0]  c_wdata, c_rdata;

  logic [7:0]  quotient, alu;
  logic        div_done;
  logic [15:0] prod;
  logic [7:0]  value_sel;

  assign src    = word_r[11:0];
  assign dst    = word_r[23:12];
  assign addr32 = 32'(addr_r);
  assign src32  = 32'(src);
  assign dst32  = 32'(dst);
  assign pc32   = 32'(pc_r);
  assign clr32  = 32'(clr_cnt_r);

  assign addr_data_ok = addr32 < DATA_DEPTH;
  assign addr_code_ok = addr32 < CODE_DEPTH;

  assign stat.clr_done  = clr32 == CLR_DEPTH - 1;
  assign stat.halted    = halted_r;
  assign stat.pc_bad    = pc32 >= CODE_DEPTH;
  assign stat.dst_bad   = dst32 >= DATA_DEPTH;
  assign stat.src_bad   = src32 >= DATA_DEPTH;
  assign stat.src_imm   = src[IMM_BIT];
  assign stat.sval_zero = sval_r == 8'd0;
  assign stat.div_done  = div_done;
  assign stat.opc       = word_r[31:24];

  // data store ports
  always_comb begin
    d_we    = 1'b0;
    d_waddr = dst32[DATA_AW-1:0];
    d_wdata = alu;
    if (cmd.clr) begin
      d_we    = clr32 < DATA_DEPTH;
      d_waddr = clr32[DATA_AW-1:0];
      d_wdata = '0;
    end else if (cmd.dwr) begin
      d_we    = addr_data_ok;
      d_waddr = addr32[DATA_AW-1:0];
      d_wdata = dbyte_r;
    end else if (cmd.wb) begin
      d_we = 1'b1;
    end
    priority if (cmd.drd_in) begin
      d_raddr = addr32[DATA_AW-1:0];
    end else if (cmd.drd_src) begin
      d_raddr = src32[DATA_AW-1:0];
    end else begin
      d_raddr = dst32[DATA_AW-1:0];
    end
  end

  always_comb begin
    if (cmd.clr) begin
      c_we    = clr32 < CODE_DEPTH;
      c_waddr = clr32[CODE_AW-1:0];
      c_wdata = '0;
    end else begin
      c_we    = cmd.cwr && addr_code_ok;
      c_waddr = addr32[CODE_AW-1:0];
      c_wdata = cword_r;
    end
  end

  bvm_ram #(.WIDTH(8), .DEPTH(DATA_DEPTH)) u_data_ram (
    .clk   (clk),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (d_raddr),
    .rdata (d_rdata)
  );

  bvm_ram #(.WIDTH(WORD_W), .DEPTH(CODE_DEPTH)) u_code_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (pc32[CODE_AW-1:0]),
    .rdata (c_rdata)
  );

  bvm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dval_r),
    .divisor  (sval_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign prod = 16'(dval_r) * 16'(sval_r);

  always_comb begin
    unique case (stat.opc)
      OP_ADD:  alu = dval_r + sval_r;
      OP_SUB:  alu = dval_r - sval_r;
      OP_MUL:  alu = prod[7:0];
      default: alu = quotient;
    endcase
  end

  always_comb begin
    unique case (cmd.vsel)
      VSEL_RD:  value_sel = addr_data_ok ? d_rdata : 8'd0;
      VSEL_SRC: value_sel = sval_r;
      default:  value_sel = 8'd0;
    endcase
  end

  always_comb begin
    pc_nxt      = cmd.ld_word ? pc_r + PC_W'(1) : pc_r;
    halted_nxt  = halted_r | cmd.set_halt;
    clr_cnt_nxt = cmd.clr ? clr_cnt_r + CLR_AW'(1) : clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= '0;
      halted_r    <= 1'b0;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      halted_r    <= halted_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= cmd.res;
    end
    if (cmd.ld_in) begin
      addr_r  <= in_address;
      dbyte_r <= in_data_byte;
      cword_r <= in_code_word;
    end
    if (cmd.ld_word) begin
      word_r <= c_rdata;
    end
    if (cmd.ld_src) begin
      sval_r <= src[IMM_BIT] ? src[7:0] : d_rdata;
    end
    if (cmd.ld_dst) begin
      dval_r <= d_rdata;
    end
    if (cmd.res) begin
      out_status_r <= cmd.res_status;
      out_value_r  <= value_sel;
      out_pc_r     <= pc_r[OUT_PC_W-1:0];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_value           = out_value_r;
  assign out_program_counter = out_pc_r;

endmodule

>>> sv/bvm_ctrl.sv
module bvm_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bvm_pkg::CMD_W-1:0] in_command,
  input  bvm_pkg::bvm_stat_t        stat,
  output bvm_pkg::bvm_cmd_t         cmd,
  output logic                      busy
);
  import bvm_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DWR   = 4'd2;
  localparam logic [3:0] S_CWR   = 4'd3;
  localparam logic [3:0] S_RD0   = 4'd4;
  localparam logic [3:0] S_RD1   = 4'd5;
  localparam logic [3:0] S_STEP  = 4'd6;
  localparam logic [3:0] S_FETCH = 4'd7;
  localparam logic [3:0] S_CHK   = 4'd8;
  localparam logic [3:0] S_SRC   = 4'd9;
  localparam logic [3:0] S_DST   = 4'd10;
  localparam logic [3:0] S_EXEC  = 4'd11;
  localparam logic [3:0] S_DIV   = 4'd12;

  logic [3:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.ld_in = 1'b1;
          unique case (in_command)
            CMD_WR_DATA: state_nxt = S_DWR;
            CMD_WR_CODE: state_nxt = S_CWR;
            CMD_STEP:    state_nxt = S_STEP;
            default:     state_nxt = S_RD0;
          endcase
        end
      end
      S_DWR: begin
        cmd.dwr = 1'b1;
        cmd.res = 1'b1;
        state_nxt = S_IDLE;
      end
      S_CWR: begin
        cmd.cwr = 1'b1;
        cmd.res = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD0: begin
        cmd.drd_in = 1'b1;
        state_nxt = S_RD1;
      end
      S_RD1: begin
        cmd.res  = 1'b1;
        cmd.vsel = VSEL_RD;
        state_nxt = S_IDLE;
      end
      S_STEP: begin
        priority if (stat.halted) begin
          cmd.res        = 1'b1;
          cmd.res_status = ST_HALTED;
          state_nxt      = S_IDLE;
        end else if (stat.pc_bad) begin
          cmd.res        = 1'b1;
          cmd.set_halt   = 1'b1;
          cmd.res_status = ST_BAD_PC;
          state_nxt      = S_IDLE;
        end else begin
          cmd.crd_pc = 1'b1;
          state_nxt  = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.ld_word = 1'b1;
        state_nxt   = S_CHK;
      end
      S_CHK: begin
        priority if (stat.dst_bad) begin
          cmd.res        = 1'b1;
          cmd.set_halt   = 1'b1;
          cmd.res_status = ST_BAD_DEST;
          state_nxt      = S_IDLE;
        end else if (!stat.src_imm && stat.src_bad) begin
          cmd.res        = 1'b1;
          cmd.set_halt   = 1'b1;
          cmd.res_status = ST_BAD_SRC;
          state_nxt      = S_IDLE;
        end else begin
          cmd.drd_src = 1'b1;
          state_nxt   = S_SRC;
        end
      end
      S_SRC: begin
        cmd.ld_src  = 1'b1;
        cmd.drd_dst = 1'b1;
        state_nxt   = S_DST;
      end
      S_DST: begin
        cmd.ld_dst = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        unique case (stat.opc)
          OP_EXIT: begin
            cmd.res        = 1'b1;
            cmd.set_halt   = 1'b1;
            cmd.res_status = ST_EXIT;
            cmd.vsel       = VSEL_SRC;
          end
          OP_ADD, OP_SUB, OP_MUL: begin
            cmd.wb  = 1'b1;
            cmd.res = 1'b1;
          end
          OP_DIV: begin
            if (stat.sval_zero) begin
              cmd.res        = 1'b1;
              cmd.set_halt   = 1'b1;
              cmd.res_status = ST_DIV_ZERO;
            end else begin
              cmd.div_start = 1'b1;
              state_nxt     = S_DIV;
            end
          end
          default: begin
            cmd.res        = 1'b1;
            cmd.set_halt   = 1'b1;
            cmd.res_status = ST_BAD_OP;
          end
        endcase
      end
      S_DIV: begin
        if (stat.div_done) begin
          cmd.wb    = 1'b1;
          cmd.res   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = state_r != S_IDLE;

endmodule

>>> bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bvm_pkg::*;

  localparam int CLK_PERIOD  = 20;
  localparam int QUIET_LIMIT = 4000;  // covers the store sweep after reset
  localparam int TAIL_CYCLES = 40;
  localparam int MAX_REPORTS = 10;
  localparam int HOT_TOP     = 15;    // small working set of data addresses
  localparam int CONST_LO    = 1020;  // kept non-zero: safe divisors

  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] dbyte;
    logic [WORD_W-1:0] cword;
    bit                drain_mark;
  } cmd_item_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [BYTE_W-1:0]   value;
    logic [OUT_PC_W-1:0] pc;
  } vm_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CMD_W-1:0]    in_command = '0;
  logic [ADDR_W-1:0]   in_address = '0;
  logic [BYTE_W-1:0]   in_data_byte = '0;
  logic [WORD_W-1:0]   in_code_word = '0;
  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [BYTE_W-1:0]   out_value;
  logic [OUT_PC_W-1:0] out_program_counter;

  byte_memory_vm_executor dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_address          (in_address),
    .in_data_byte        (in_data_byte),
    .in_code_word        (in_code_word),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_value           (out_value),
    .out_program_counter (out_program_counter)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // machine state as the block should hold it
  logic [BYTE_W-1:0] data_mem [DATA_DEPTH];
  logic [WORD_W-1:0] code_mem [CODE_DEPTH];
  logic [PC_W-1:0]   vm_pc;
  logic              vm_halted;

  cmd_item_t  cmd_queue [$];
  vm_result_t due_results [$];
  int  mismatches = 0;
  int  quiet_cycles = 0;
  int  sent_count = 0;
  int  gen_pc = 0;
  bit  word_taken = 1'b0;

  function automatic vm_result_t apply_command(logic [CMD_W-1:0] cmd,
      logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] dbyte, logic [WORD_W-1:0] cword);
    vm_result_t r;
    logic [WORD_W-1:0] w;
    logic [7:0] opc;
    logic [11:0] dst, src;
    logic [BYTE_W-1:0] sval, dval;
    r.status = ST_OK;
    r.value  = '0;
    case (cmd)
      CMD_WR_DATA: data_mem[addr] = dbyte;
      CMD_WR_CODE: code_mem[addr] = cword;
      CMD_RD_DATA: r.value = data_mem[addr];
      default: begin
        if (vm_halted) begin
          r.status = ST_HALTED;
        end else if (vm_pc >= CODE_DEPTH) begin
          vm_halted = 1'b1;
          r.status  = ST_BAD_PC;
        end else begin
          w = code_mem[vm_pc[CODE_AW-1:0]];
          vm_pc = vm_pc + PC_W'(1);
          {opc, dst, src} = w;
          if (dst >= DATA_DEPTH) begin
            vm_halted = 1'b1;
            r.status  = ST_BAD_DEST;
          end else if (!src[IMM_BIT] && src >= DATA_DEPTH) begin
            vm_halted = 1'b1;
            r.status  = ST_BAD_SRC;
          end else begin
            sval = src[IMM_BIT] ? src[7:0] : data_mem[src[DATA_AW-1:0]];
            dval = data_mem[dst[DATA_AW-1:0]];
            case (opc)
              OP_EXIT: begin
                r.value   = sval;
                vm_halted = 1'b1;
                r.status  = ST_EXIT;
              end
              OP_ADD: data_mem[dst[DATA_AW-1:0]] = dval + sval;
              OP_SUB: data_mem[dst[DATA_AW-1:0]] = dval - sval;
              OP_MUL: data_mem[dst[DATA_AW-1:0]] = dval * sval;
              OP_DIV: begin
                if (sval == '0) begin
                  vm_halted = 1'b1;
                  r.status  = ST_DIV_ZERO;
                end else begin
                  data_mem[dst[DATA_AW-1:0]] = dval / sval;
                end
              end
              default: begin
                vm_halted = 1'b1;
                r.status  = ST_BAD_OP;
              end
            endcase
          end
        end
      end
    endcase
    r.pc = vm_pc[OUT_PC_W-1:0];
    return r;
  endfunction

  function automatic void push_cmd(logic [CMD_W-1:0] cmd, int addr, int dbyte,
      logic [WORD_W-1:0] cword);
    cmd_item_t it;
    it.cmd        = cmd;
    it.addr       = addr[ADDR_W-1:0];
    it.dbyte      = dbyte[BYTE_W-1:0];
    it.cword      = cword;
    it.drain_mark = 1'b0;
    cmd_queue.push_back(it);
  endfunction

  function automatic void push_drain();
    cmd_item_t it;
    it = '{cmd: CMD_STEP, addr: '0, dbyte: '0, cword: '0, drain_mark: 1'b1};
    cmd_queue.push_back(it);
  endfunction

  // byte for a data write; the divisor bytes never become zero while running
  function automatic int safe_byte(int addr);
    return (addr >= CONST_LO) ? $urandom_range(1, 255) : $urandom_range(0, 255);
  endfunction

  function automatic logic [11:0] rand_imm(bit nonzero);
    logic [11:0] s;
    s = {1'b1, 3'($urandom_range(0, 7)), 8'($urandom_range(nonzero ? 1 : 0, 255))};
    return s;
  endfunction

  // well-formed instruction that keeps the machine running
  function automatic logic [WORD_W-1:0] rand_instr();
    logic [7:0]  op;
    logic [11:0] dst, src;
    case ($urandom_range(0, 3))
      0: op = OP_ADD;
      1: op = OP_SUB;
      2: op = OP_MUL;
      default: op = OP_DIV;
    endcase
    dst = ($urandom_range(0, 3) != 0) ? 12'($urandom_range(0, HOT_TOP))
                                       : 12'($urandom_range(HOT_TOP + 1, CONST_LO - 1));
    if ($urandom_range(0, 2) == 0) begin
      src = rand_imm(op == OP_DIV);
    end else if (op == OP_DIV) begin
      src = 12'($urandom_range(CONST_LO, DATA_DEPTH - 1));
    end else begin
      case ($urandom_range(0, 2))
        0: src = 12'($urandom_range(0, HOT_TOP));
        1: src = 12'($urandom_range(CONST_LO, DATA_DEPTH - 1));
        default: src = 12'($urandom_range(0, DATA_DEPTH - 1));
      endcase
    end
    return {op, dst, src};
  endfunction

  // driver: presents the next word once the previous one has gone in
  always @(negedge clk) begin
    cmd_item_t it;
    logic go;
    bit gaps_on;
    if (rst_n && (word_taken || !start)) begin
      word_taken = 1'b0;
      go = 1'b0;
      gaps_on = !(sent_count >= 700 && sent_count < 1000);
      if (cmd_queue.size() > 0 && cmd_queue[0].drain_mark && due_results.size() == 0)
        void'(cmd_queue.pop_front());
      if (cmd_queue.size() > 0 && !cmd_queue[0].drain_mark &&
          !(gaps_on && $urandom_range(0, 99) < 12)) begin
        it = cmd_queue.pop_front();
        go = 1'b1;
        in_command   <= it.cmd;
        in_address   <= it.addr;
        in_data_byte <= it.dbyte;
        in_code_word <= it.cword;
        sent_count++;
      end
      start <= go;
    end
  end

  // monitor: check results, then record the word accepted at this edge
  always @(posedge clk) begin
    vm_result_t exp_r;
    if (rst_n) begin
      if (out_valid) begin
        if (due_results.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("%0t: result with nothing due: status %0d value %0h pc %0d",
                     $realtime, out_status, out_value, out_program_counter);
          mismatches++;
        end else begin
          exp_r = due_results.pop_front();
          if (out_status !== exp_r.status || out_value !== exp_r.value ||
              out_program_counter !== exp_r.pc) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t: mismatch: expected status %0d value %0h pc %0d, got %0d %0h %0d",
                       $realtime, exp_r.status, exp_r.value, exp_r.pc,
                       out_status, out_value, out_program_counter);
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        due_results.push_back(apply_command(in_command, in_address, in_data_byte,
                                            in_code_word));
        word_taken = 1'b1;
      end
    end
    if (rst_n && ((start && !busy) || out_valid))
      quiet_cycles = 0;
    else
      quiet_cycles++;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int k, a, kind;
    logic [7:0]  op;
    logic [11:0] dst, src;
    foreach (data_mem[i]) data_mem[i] = '0;
    foreach (code_mem[i]) code_mem[i] = '0;
    vm_pc     = '0;
    vm_halted = 1'b0;

    // directed: cleared store, extremes, each arithmetic op
    push_cmd(CMD_RD_DATA, 0, 0, '0);
    push_cmd(CMD_WR_DATA, 1023, 8'hff, '0);
    push_cmd(CMD_WR_DATA, 1022, 8'h01, '0);
    push_cmd(CMD_WR_DATA, 1021, 8'h80, '0);
    push_cmd(CMD_WR_DATA, 1020, 8'h07, '0);
    push_cmd(CMD_WR_DATA, 0, 8'hff, '0);
    push_cmd(CMD_WR_DATA, 1, 8'h00, '0);
    push_cmd(CMD_RD_DATA, 1023, 0, '0);
    push_cmd(CMD_WR_CODE, 0, 0, {OP_ADD, 12'd0, 12'h801});      // 0xff + 1 wraps
    push_cmd(CMD_WR_CODE, 1, 0, {OP_SUB, 12'd1, 12'd1022});     // 0 - 1 wraps
    push_cmd(CMD_WR_CODE, 2, 0, {OP_MUL, 12'd1, 12'hfff});      // ignored imm bits set
    push_cmd(CMD_WR_CODE, 3, 0, {OP_DIV, 12'd1, 12'd1020});
    for (int i = 0; i < 4; i++) push_cmd(CMD_STEP, 0, 0, '0);
    gen_pc = 4;
    push_cmd(CMD_RD_DATA, 0, 0, '0);
    push_cmd(CMD_RD_DATA, 1, 0, '0);
    push_cmd(CMD_WR_CODE, 0, 0, 32'hffff_ffff);                 // already executed
    push_drain();

    // random: short runs of well-formed code, each word written just ahead of its step
    while (cmd_queue.size() < 1750 && gen_pc < 1000) begin
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++) push_cmd(CMD_WR_CODE, gen_pc + i, 0, rand_instr());
      if ($urandom_range(0, 1) == 0) begin
        a = ($urandom_range(0, 3) == 0) ? $urandom_range(CONST_LO, DATA_DEPTH - 1)
                                        : $urandom_range(0, HOT_TOP);
        push_cmd(CMD_WR_DATA, a, safe_byte(a), '0);
      end
      for (int i = 0; i < k; i++) push_cmd(CMD_STEP, 0, 0, '0);
      gen_pc += k;
      if ($urandom_range(0, 1) == 0) push_cmd(CMD_RD_DATA, $urandom_range(0, HOT_TOP), 0, '0);
      case ($urandom_range(0, 7))
        0: push_cmd(CMD_WR_CODE, $urandom_range(0, gen_pc - 1), 0, 32'($urandom));
        1: begin
          a = $urandom_range(0, DATA_DEPTH - 1);
          push_cmd(CMD_WR_DATA, a, safe_byte(a), '0);
        end
        2: push_cmd(CMD_RD_DATA, $urandom_range(0, DATA_DEPTH - 1), 0, '0);
        default: ;
      endcase
      if ($urandom_range(0, 49) == 0) push_drain();
    end

    // one way of stopping, chosen by the seed; the machine stays halted from here
    kind = $urandom_range(0, 5);
    dst = 12'($urandom_range(0, DATA_DEPTH - 1));
    src = ($urandom_range(0, 1) == 0) ? rand_imm(1'b0) : 12'($urandom_range(0, DATA_DEPTH - 1));
    op  = 8'($urandom_range(0, 255));
    case (kind)
      0: op = OP_EXIT;
      1: dst = 12'($urandom_range(DATA_DEPTH, 4095));
      2: src = 12'($urandom_range(DATA_DEPTH, 2047));
      3: begin
        op = 8'($urandom_range(4, 254));
        if (op >= OP_EXIT) op = op + 8'd1;
      end
      4: begin
        op  = OP_DIV;
        src = {1'b1, 3'($urandom_range(0, 7)), 8'h00};
      end
      default: begin
        // run the cleared code store out to the end
        while (gen_pc < CODE_DEPTH) begin
          push_cmd(CMD_STEP, 0, 0, '0);
          gen_pc++;
        end
      end
    endcase
    if (gen_pc < CODE_DEPTH) push_cmd(CMD_WR_CODE, gen_pc, 0, {op, dst, src});
    push_cmd(CMD_STEP, 0, 0, '0);
    push_drain();
    for (int i = 0; i < 3; i++) push_cmd(CMD_STEP, 0, 0, '0);
    push_cmd(CMD_WR_CODE, 1023, 0, 32'hffff_ffff);
    push_cmd(CMD_WR_CODE, 0, 0, 32'h0000_0000);
    for (int i = 0; i < 30; i++) begin
      a = $urandom_range(0, DATA_DEPTH - 1);
      if ($urandom_range(0, 1) == 0) push_cmd(CMD_WR_DATA, a, $urandom_range(0, 255), '0);
      push_cmd(CMD_RD_DATA, a, 0, '0);
    end
    for (int i = 0; i <= HOT_TOP; i++) push_cmd(CMD_RD_DATA, i, 0, '0);
    push_cmd(CMD_STEP, 0, 0, '0);

    while (cmd_queue.size() != 0 || start) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (due_results.size() != 0) begin
      $display("%0d results never arrived", due_results.size());
      mismatches++;
    end
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
